### hdl/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

  localparam int COLOR_W = 8;
  localparam int SLOT_W  = 6;
  localparam int DIST_W  = 18;
  localparam int COUNT_W = 7;

  // Largest squared RGB distance, 3 * 255^2
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(195075);

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  typedef struct packed {
    logic               command;
    logic [SLOT_W-1:0]  entry_index;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } npc_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  best_index;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic [DIST_W-1:0]  best_distance;
  } npc_rsp_t;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } npc_rgb_t;

  // Entry tap from the read stage into the distance unit
  typedef struct packed {
    logic valid;
    logic first;
  } npc_tap_t;

endpackage

### hdl/npc_palette_mem.sv
`timescale 1ns / 1ps

module npc_palette_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  npc_pkg::npc_rgb_t wdata,
  input  logic [AW-1:0]     raddr,
  output npc_pkg::npc_rgb_t rdata
);
  import npc_pkg::*;

  npc_rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/npc_dist_unit.sv
`timescale 1ns / 1ps

module npc_dist_unit #(
  parameter int AW = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  npc_pkg::npc_tap_t tap,
  input  logic [AW-1:0]     tap_idx,
  input  npc_pkg::npc_rgb_t entry,
  input  npc_pkg::npc_rgb_t pixel,
  output logic              busy,
  output logic [AW-1:0]     best_idx,
  output npc_pkg::npc_rgb_t best_rgb,
  output logic [npc_pkg::DIST_W-1:0] best_dist
);
  import npc_pkg::*;

  function automatic logic [2*COLOR_W-1:0] sq_diff(
    input logic [COLOR_W-1:0] a,
    input logic [COLOR_W-1:0] b
  );
    logic [COLOR_W-1:0]   d;
    logic [2*COLOR_W-1:0] dw;
    d  = (a >= b) ? (a - b) : (b - a);
    dw = {{COLOR_W{1'b0}}, d};
    return dw * dw;
  endfunction

  // square stage
  logic                   sq_valid;
  logic                   sq_first;
  logic [AW-1:0]          sq_idx;
  npc_rgb_t               sq_rgb;
  logic [2*COLOR_W-1:0]   sq_r;
  logic [2*COLOR_W-1:0]   sq_g;
  logic [2*COLOR_W-1:0]   sq_b;
  logic [DIST_W-1:0]      sum_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= tap.valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_first <= tap.first;
    sq_idx   <= tap_idx;
    sq_rgb   <= entry;
    sq_r     <= sq_diff(pixel.r, entry.r);
    sq_g     <= sq_diff(pixel.g, entry.g);
    sq_b     <= sq_diff(pixel.b, entry.b);
  end

  assign sum_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  // strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (sq_valid && (sq_first || (sum_dist < best_dist))) begin
      best_dist <= sum_dist;
      best_idx  <= sq_idx;
      best_rgb  <= sq_rgb;
    end
  end

  assign busy = sq_valid;

endmodule

### hdl/nearest_palette_color_top.sv
// Nearest palette color. A request transaction with command CMD_WRITE stores
// one RGB entry at entry_index (slots at or above PALETTE_DEPTH are dropped)
// and returns nothing; a request with command CMD_MAP carries a pixel and
// returns one response transaction: the lowest index with the smallest squared
// RGB distance, that entry's color and the distance. Entries 0 to
// palette_count-1 are searched (a count of 0 searches entry 0, a count above
// PALETTE_DEPTH searches the whole palette); every searched entry must have
// been written first. A map streams one palette entry per cycle out of the
// synchronous RAM through a shared square-and-sum unit and a compare stage;
// req_stall is high while the map is in progress, until its response is taken.
// palette_count is written through cfg_we/cfg_data and resets to 1; the user
// must write it only while the block is idle, which the block does not enforce.
// The palette RAM is not cleared by reset.
`timescale 1ns / 1ps

module nearest_palette_color_top #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  npc_pkg::npc_req_t             req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output npc_pkg::npc_rsp_t             rsp,
  input  logic                          cfg_we,
  input  logic [npc_pkg::COUNT_W-1:0]   cfg_data
);
  import npc_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [COUNT_W-1:0] palette_count;
  logic [AW-1:0]      scan_last;
  logic [AW-1:0]      scan_addr;
  logic               rd_valid;      // RAM output holds entry rd_idx
  logic [AW-1:0]      rd_idx;
  npc_rgb_t           pixel;
  npc_rgb_t           rd_rgb;
  npc_rgb_t           wr_rgb;
  npc_tap_t           tap;
  logic               dist_busy;
  logic [AW-1:0]      best_idx;
  npc_rgb_t           best_rgb;
  logic [DIST_W-1:0]  best_dist;
  logic               req_take;
  logic               wr_en;

  assign req_take = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign wr_en = req_take && (req.command == CMD_WRITE)
                 && (32'(req.entry_index) < PALETTE_DEPTH);
  assign wr_rgb = '{r: req.red_in, g: req.green_in, b: req.blue_in};

  // Last index searched: count clamped to 1..PALETTE_DEPTH, minus one
  always_comb begin
    if (palette_count == '0) begin
      scan_last = '0;
    end else if (32'(palette_count) > PALETTE_DEPTH) begin
      scan_last = AW'(PALETTE_DEPTH - 1);
    end else begin
      scan_last = AW'(palette_count - COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      palette_count <= cfg_data;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take && (req.command == CMD_MAP)) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (scan_addr == scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !dist_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_ISSUE);
    end
  end

  // Read address walks 0..scan_last, one entry per cycle
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      scan_addr <= '0;
    end else if (state == ST_ISSUE && scan_addr != scan_last) begin
      scan_addr <= scan_addr + AW'(1);
    end
    rd_idx <= scan_addr;
    if (req_take) begin
      pixel <= wr_rgb;
    end
  end

  npc_palette_mem #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(req.entry_index)),
    .wdata (wr_rgb),
    .raddr (scan_addr),
    .rdata (rd_rgb)
  );

  assign tap = '{valid: rd_valid, first: (rd_idx == '0)};

  npc_dist_unit #(
    .AW (AW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .tap       (tap),
    .tap_idx   (rd_idx),
    .entry     (rd_rgb),
    .pixel     (pixel),
    .busy      (dist_busy),
    .best_idx  (best_idx),
    .best_rgb  (best_rgb),
    .best_dist (best_dist)
  );

  // Result registers in the distance unit hold still while DONE waits
  assign rsp_valid = (state == ST_DONE);
  assign rsp = '{best_index:    SLOT_W'(best_idx),
                 red_out:       best_rgb.r,
                 green_out:     best_rgb.g,
                 blue_out:      best_rgb.b,
                 best_distance: best_dist};

  // A map request starts the scan on the next cycle
  a_map_starts: assert property (@(posedge clk) disable iff (rst)
    req_take && (req.command == CMD_MAP) |=> (state == ST_ISSUE))
    else $error("map request did not start scan");

  // The address walk never passes the last searched entry
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> (scan_addr <= scan_last))
    else $error("scan address beyond count");

  // A response never carries an unsearched index or an impossible distance
  a_rsp_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (best_idx <= scan_last) && (best_dist <= DIST_MAX))
    else $error("response out of range");

  // Nothing is left in flight when the response is shown
  a_drained: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !rd_valid && !dist_busy)
    else $error("response before pipeline drained");

endmodule

### test/nearest_palette_color_top_tb.sv
`timescale 1ns / 1ps

module nearest_palette_color_top_tb;
  import npc_pkg::*;

  localparam int PALETTE_DEPTH = 64;
  // A palette write may still be in flight after the last response
  localparam int SETTLE_CYCLES = 8;
  // Full search plus pipeline, used as the quiet tail at the end
  localparam int TAIL_CYCLES = PALETTE_DEPTH + 8;
  localparam int HOLD_OFF_CYCLES = 400;
  // Cycles with no accepted transaction on either side before giving up
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 120;
  localparam int MAX_REPORTS = 40;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  npc_req_t             req;
  logic                 rsp_valid;
  logic                 rsp_stall;
  npc_rsp_t             rsp;
  logic                 cfg_we;
  logic [COUNT_W-1:0]   cfg_data;

  // Shadow copy of the palette and of the count register
  npc_rgb_t             shade_mem [PALETTE_DEPTH];
  logic [COUNT_W-1:0]   count_setting;
  // Expected responses, oldest first
  npc_rsp_t             pending_matches [$];
  npc_rsp_t             want;

  int unsigned          fail_count;
  int unsigned          quiet_cycles = 0;
  // calm: no idling on either side; hold_off_pending: ask for a long rsp stall
  bit                   calm;
  bit                   hold_off_pending;

  nearest_palette_color_top #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Count 0 still searches entry 0; anything past the depth searches it all.
  function automatic int unsigned searched_entries();
    if (count_setting == 0) return 1;
    if (count_setting > PALETTE_DEPTH) return PALETTE_DEPTH;
    return 32'(count_setting);
  endfunction

  function automatic int unsigned rgb_distance(npc_rgb_t a, npc_rgb_t b);
    int dr, dg, db;
    dr = int'(a.r) - int'(b.r);
    dg = int'(a.g) - int'(b.g);
    db = int'(a.b) - int'(b.b);
    return dr * dr + dg * dg + db * db;
  endfunction

  // Strict less-than keeps the lowest index on a tie.
  function automatic npc_rsp_t nearest_entry(npc_rgb_t px);
    npc_rsp_t    best;
    int unsigned n, d, best_d, best_i;
    n      = searched_entries();
    best_i = 0;
    best_d = rgb_distance(px, shade_mem[0]);
    for (int unsigned i = 1; i < n; i++) begin
      d = rgb_distance(px, shade_mem[i]);
      if (d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    best.best_index    = SLOT_W'(best_i);
    best.red_out       = shade_mem[best_i].r;
    best.green_out     = shade_mem[best_i].g;
    best.blue_out      = shade_mem[best_i].b;
    best.best_distance = DIST_W'(best_d);
    return best;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic npc_rgb_t rgb(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
    npc_rgb_t c;
    c.r = r;
    c.g = g;
    c.b = b;
    return c;
  endfunction

  function automatic npc_req_t write_item(int unsigned slot, npc_rgb_t c);
    npc_req_t it;
    it.command     = CMD_WRITE;
    it.entry_index = SLOT_W'(slot);
    it.red_in      = c.r;
    it.green_in    = c.g;
    it.blue_in     = c.b;
    return it;
  endfunction

  // entry_index is don't-care on a map, so it gets random bits
  function automatic npc_req_t map_item(npc_rgb_t px);
    npc_req_t it;
    it.command     = CMD_MAP;
    it.entry_index = SLOT_W'($urandom);
    it.red_in      = px.r;
    it.green_in    = px.g;
    it.blue_in     = px.b;
    return it;
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] v);
    int x;
    x = int'(v) + $urandom_range(0, 12) - 6;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return 8'(x);
  endfunction

  // Mix of uniform pixels, exact palette hits, near misses and corner colors
  function automatic npc_rgb_t pick_pixel();
    npc_rgb_t    base;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    base = shade_mem[$urandom_range(0, searched_entries() - 1)];
    case (roll)
      0, 1, 2: begin
        return rgb(8'($urandom), 8'($urandom), 8'($urandom));
      end
      3: begin
        return base;
      end
      4: begin
        return rgb($urandom_range(0, 1) ? 8'hFF : 8'h00,
                   $urandom_range(0, 1) ? 8'hFF : 8'h00,
                   $urandom_range(0, 1) ? 8'hFF : 8'h00);
      end
      default: begin
        return rgb(nudge(base.r), nudge(base.g), nudge(base.b));
      end
    endcase
  endfunction

  function automatic npc_req_t random_item();
    npc_rgb_t    c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      // Copying another slot's color sets up ties
      if (roll < 8) c = shade_mem[$urandom_range(0, PALETTE_DEPTH - 1)];
      else if (roll < 12) c = rgb(8'h00, 8'hFF, 8'($urandom));
      else c = rgb(8'($urandom), 8'($urandom), 8'($urandom));
      return write_item($urandom_range(0, PALETTE_DEPTH - 1), c);
    end
    return map_item(pick_pixel());
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one transaction, hold it until accepted, then update the shadow
  // state. req_valid stays high on return so a follow-on item goes out
  // back-to-back.
  task automatic send_item(input npc_req_t item);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (item.command == CMD_WRITE) begin
      shade_mem[item.entry_index] = rgb(item.red_in, item.green_in, item.blue_in);
    end else begin
      pending_matches = {pending_matches,
                         nearest_entry(rgb(item.red_in, item.green_in, item.blue_in))};
    end
  endtask

  // Sender goes quiet until every expected response is back, then lets any
  // trailing palette write finish.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic write_count(input int unsigned value);
    cfg_data <= COUNT_W'(value);
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we        <= 1'b0;
    count_setting = COUNT_W'(value);
  endtask

  // Response-side stall: random bursts, or one long hold-off on request
  initial begin : rsp_stall_driver
    int unsigned burst;
    burst = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
        burst = 0;
      end else if (burst != 0) begin
        burst--;
        rsp_stall <= 1'b1;
      end else begin
        burst = ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
        rsp_stall <= (burst != 0);
        if (burst != 0) burst--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("t=%0t %s", $time, what);
  endtask

  // Each accepted response is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("response with none pending, index %0d",
                                  rsp.best_index));
      end else begin
        want = pending_matches.pop_front();
        if (rsp.best_index !== want.best_index)
          report_mismatch($sformatf("best_index %0d, want %0d",
                                    rsp.best_index, want.best_index));
        if (rsp.red_out !== want.red_out)
          report_mismatch($sformatf("red_out %0d, want %0d",
                                    rsp.red_out, want.red_out));
        if (rsp.green_out !== want.green_out)
          report_mismatch($sformatf("green_out %0d, want %0d",
                                    rsp.green_out, want.green_out));
        if (rsp.blue_out !== want.blue_out)
          report_mismatch($sformatf("blue_out %0d, want %0d",
                                    rsp.blue_out, want.blue_out));
        if (rsp.best_distance !== want.best_distance)
          report_mismatch($sformatf("best_distance %0d, want %0d",
                                    rsp.best_distance, want.best_distance));
      end
    end
  end

  // Watchdog: too long without any accepted transaction means a hang
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("nearest_palette_color_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Count comes out of reset at 1: only entry 0 is searched even though
  // entry 1 is an exact hit.
  task automatic test_reset_count();
    send_item(write_item(0, rgb(8'h10, 8'h20, 8'h30)));
    send_item(write_item(1, rgb(8'd200, 8'd100, 8'd50)));
    send_item(map_item(rgb(8'd200, 8'd100, 8'd50)));
    wait_drained();
  endtask

  // Count of zero, largest distance, zero distance, ties on distance and
  // on identical colors.
  task automatic test_small_counts_and_ties();
    send_item(write_item(0, rgb(8'h00, 8'h00, 8'h00)));
    send_item(write_item(1, rgb(8'hFF, 8'hFF, 8'hFF)));
    wait_drained();
    write_count(0);
    send_item(map_item(rgb(8'hFF, 8'hFF, 8'hFF)));
    send_item(map_item(rgb(8'h00, 8'h00, 8'h00)));
    wait_drained();
    write_count(2);
    send_item(map_item(rgb(8'hFF, 8'hFF, 8'hFF)));
    send_item(map_item(rgb(8'h00, 8'h00, 8'h00)));
    send_item(map_item(rgb(8'h80, 8'h7F, 8'h80)));
    // equal distance, different colors: lower slot wins
    send_item(write_item(0, rgb(8'd10, 8'd0, 8'd0)));
    send_item(write_item(1, rgb(8'd0, 8'd10, 8'd0)));
    send_item(map_item(rgb(8'h00, 8'h00, 8'h00)));
    // identical colors
    send_item(write_item(1, rgb(8'd10, 8'd0, 8'd0)));
    send_item(map_item(rgb(8'd12, 8'd3, 8'd0)));
    wait_drained();
    write_count(1);
    send_item(map_item(rgb(8'hFF, 8'hFF, 8'hFF)));
    wait_drained();
  endtask

  // Load every slot, then search the whole palette, including a count past
  // the depth that must clamp.
  task automatic test_full_palette();
    for (int unsigned i = 0; i < PALETTE_DEPTH - 1; i++)
      send_item(write_item(i, rgb(8'($urandom), 8'($urandom), 8'($urandom))));
    send_item(write_item(PALETTE_DEPTH - 1, rgb(8'hFF, 8'h00, 8'hFF)));
    wait_drained();
    write_count(127);
    send_item(map_item(rgb(8'hFF, 8'h00, 8'hFF)));
    send_item(map_item(rgb(8'hFF, 8'hFF, 8'hFF)));
    wait_drained();
    write_count(PALETTE_DEPTH);
    send_item(map_item(rgb(8'hFF, 8'h00, 8'hFF)));
    send_item(map_item(rgb(8'h00, 8'h00, 8'h00)));
    wait_drained();
    write_count(PALETTE_DEPTH + 1);
    send_item(map_item(rgb(8'hFE, 8'h01, 8'hFE)));
    wait_drained();
  endtask

  // Phases of mixed writes and maps, each under its own count
  task automatic test_random_traffic();
    int unsigned phase_counts [10];
    phase_counts = '{64, 1, 0, 127, 2, 17, 65, 40, 63, 64};
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      write_count((p == 8) ? $urandom_range(0, 127) : phase_counts[p]);
      calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_item(random_item());
    end
    calm = 1'b0;
    wait_drained();
  endtask

  // Receiver holds off a long time while the sender keeps pushing maps,
  // so the block backs up and stalls its request side.
  task automatic test_backpressure();
    wait_drained();
    write_count(PALETTE_DEPTH);
    calm = 1'b1;
    hold_off_pending = 1'b1;
    repeat (24) send_item(map_item(pick_pixel()));
    calm = 1'b0;
    wait_drained();
  endtask

  // Short bursts, each followed by a full drain before the next
  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(3, 12)) send_item(random_item());
      wait_drained();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    fail_count       = 0;
    calm             = 1'b0;
    hold_off_pending = 1'b0;
    count_setting    = COUNT_W'(1);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_count();
    test_small_counts_and_ties();
    test_full_palette();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();

    // Quiet tail: anything showing up now has no expectation behind it
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_matches.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived",
                                pending_matches.size()));
    if (fail_count == 0) begin
      $display("nearest_palette_color_top: match");
    end else begin
      $display("nearest_palette_color_top: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hdl/npc_pkg.sv
hdl/npc_palette_mem.sv
hdl/npc_dist_unit.sv
hdl/nearest_palette_color_top.sv
test/nearest_palette_color_top_tb.sv
